// File: sv/qutrit_stabilizer_tableau_top_assert.svh
// Assertion macros for the qutrit stabilizer tableau block.
// Define ASSERT_OFF to compile every check to nothing.
`ifndef QUTRIT_STABILIZER_TABLEAU_TOP_ASSERT_SVH
`define QUTRIT_STABILIZER_TABLEAU_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define QST_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define QST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define QST_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define QST_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/qst_pkg.sv
// Shared types, codes and mod-3 helpers for the qutrit stabilizer tableau.
// No dependencies.
package qst_pkg;

  localparam logic [2:0] ACT_H3      = 3'd0;
  localparam logic [2:0] ACT_S3      = 3'd1;
  localparam logic [2:0] ACT_CZ3     = 3'd2;
  localparam logic [2:0] ACT_XPOW    = 3'd3;
  localparam logic [2:0] ACT_ZPOW    = 3'd4;
  localparam logic [2:0] ACT_MEASURE = 3'd5;
  localparam logic [2:0] ACT_REINIT  = 3'd6;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAME  = 2'd2;

  typedef enum logic [1:0] {
    KIND_GATE,
    KIND_MEASURE,
    KIND_REINIT,
    KIND_REPORT
  } kind_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] qutrit_a;
    logic [3:0] qutrit_b;
    logic [1:0] gate_power;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] outcome;
    logic       random_flag;
  } res_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] action;
    logic [3:0] qutrit_a;
    logic [3:0] qutrit_b;
    logic [1:0] power;
    logic [1:0] status;
  } cmd_t;

  function automatic logic [1:0] trit_add(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

  function automatic logic [1:0] trit_mul(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] p;
    case ({a, b})
      4'b0101: p = 2'd1;
      4'b0110: p = 2'd2;
      4'b1001: p = 2'd2;
      4'b1010: p = 2'd1;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// File: sv/qst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qst_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/qst_fifo.sv
// Small register queue with push/full and pop/empty sides.
// No dependencies.
module qst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/qst_front.sv
// Front end: accepts requests, holds qutrit_count, checks indexes and queues commands.
// Depends on qst_pkg and qst_fifo.
module qst_front #(
  parameter int MAX_QUTRITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  qst_pkg::req_t request,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_data,
  output logic [4:0]    count,
  output logic          cmd_empty,
  input  logic          cmd_pop,
  output qst_pkg::cmd_t cmd
);

  localparam logic [4:0] COUNT_RESET =
    (MAX_QUTRITS < 16) ? 5'(MAX_QUTRITS) : 5'd16;

  logic [4:0]    count_next;
  logic          a_bad;
  logic          b_bad;
  qst_pkg::cmd_t cmd_in;

  always_comb begin
    count_next = cfg_data;
    if (cfg_data == 5'd0) begin
      count_next = 5'd1;
    end else if (int'(cfg_data) > MAX_QUTRITS) begin
      count_next = 5'(MAX_QUTRITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_RESET;
    end else if (cfg_we) begin
      count <= count_next;
    end
  end

  assign a_bad = ({1'b0, request.qutrit_a} >= count);
  assign b_bad = ({1'b0, request.qutrit_b} >= count);

  always_comb begin
    cmd_in.action   = request.action;
    cmd_in.qutrit_a = request.qutrit_a;
    cmd_in.qutrit_b = request.qutrit_b;
    cmd_in.power    = (request.gate_power == 2'd3) ? 2'd0 : request.gate_power;
    cmd_in.status   = qst_pkg::STATUS_OK;
    cmd_in.kind     = qst_pkg::KIND_REPORT;
    if (request.action == qst_pkg::ACT_CZ3 && request.qutrit_a == request.qutrit_b) begin
      cmd_in.status = qst_pkg::STATUS_SAME;
    end else if (request.action <= qst_pkg::ACT_MEASURE &&
                 (a_bad || (request.action == qst_pkg::ACT_CZ3 && b_bad))) begin
      cmd_in.status = qst_pkg::STATUS_RANGE;
    end else begin
      unique case (request.action) inside
        qst_pkg::ACT_H3, qst_pkg::ACT_S3, qst_pkg::ACT_CZ3,
        qst_pkg::ACT_XPOW, qst_pkg::ACT_ZPOW: cmd_in.kind = qst_pkg::KIND_GATE;
        qst_pkg::ACT_MEASURE: cmd_in.kind = qst_pkg::KIND_MEASURE;
        qst_pkg::ACT_REINIT:  cmd_in.kind = qst_pkg::KIND_REINIT;
        default:              cmd_in.kind = qst_pkg::KIND_REPORT;
      endcase
    end
  end

  qst_fifo #(
    .WIDTH($bits(qst_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .wdata(cmd_in),
    .pop  (cmd_pop),
    .empty(cmd_empty),
    .rdata(cmd)
  );

endmodule

// File: sv/qst_back.sv
// Back end: walks tableau rows one per cycle through the row RAM and queues results.
// Depends on qst_pkg, qst_ram, qst_fifo and the assertion macro header.
`include "qutrit_stabilizer_tableau_top_assert.svh"
module qst_back #(
  parameter int MAX_QUTRITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [4:0]    count,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  qst_pkg::cmd_t cmd,
  output logic          empty,
  input  logic          pop,
  output qst_pkg::res_t result
);

  localparam int IW = (MAX_QUTRITS > 1) ? $clog2(MAX_QUTRITS) : 1;
  localparam int RW = 4 * MAX_QUTRITS + 2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                      state;
  qst_pkg::cmd_t               cur;
  logic [4:0]                  row;
  logic                        s1_valid;
  logic [IW-1:0]               s1_addr;
  logic [MAX_QUTRITS-1:0]      row_valid;
  logic                        found;
  logic [1:0]                  meas_outcome;

  logic [RW-1:0]               rd_word;
  logic [RW-1:0]               wr_word;
  logic                        ram_we;
  logic                        ram_re;
  logic [MAX_QUTRITS-1:0][1:0] x_old;
  logic [MAX_QUTRITS-1:0][1:0] z_old;
  logic [1:0]                  p_old;
  logic [MAX_QUTRITS-1:0][1:0] x_new;
  logic [MAX_QUTRITS-1:0][1:0] z_new;
  logic [1:0]                  p_new;
  logic [IW-1:0]               col_a;
  logic [IW-1:0]               col_b;
  logic [1:0]                  xa;
  logic [1:0]                  za;
  logic [1:0]                  xb;
  logic [1:0]                  zb;
  logic                        res_push;
  logic                        res_full;
  qst_pkg::res_t               res_in;

  assign cmd_pop = (state == ST_IDLE) && !cmd_empty;
  assign ram_re  = (state == ST_RUN);
  assign col_a   = IW'(cur.qutrit_a);
  assign col_b   = IW'(cur.qutrit_b);

  qst_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_QUTRITS)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_addr),
    .wdata(wr_word),
    .re   (ram_re),
    .raddr(IW'(row)),
    .rdata(rd_word)
  );

  always_comb begin
    for (int j = 0; j < MAX_QUTRITS; j++) begin
      if (row_valid[s1_addr]) begin
        x_old[j] = rd_word[2*j +: 2];
        z_old[j] = rd_word[2*MAX_QUTRITS + 2*j +: 2];
      end else begin
        x_old[j] = 2'd0;
        z_old[j] = (IW'(j) == s1_addr) ? 2'd1 : 2'd0;
      end
    end
    p_old = row_valid[s1_addr] ? rd_word[RW-1 -: 2] : 2'd0;
  end

  assign xa = x_old[col_a];
  assign za = z_old[col_a];
  assign xb = x_old[col_b];
  assign zb = z_old[col_b];

  always_comb begin
    x_new = x_old;
    z_new = z_old;
    p_new = p_old;
    unique case (cur.action)
      qst_pkg::ACT_H3: begin
        p_new        = qst_pkg::trit_add(p_old,
                         qst_pkg::trit_mul(2'd2, qst_pkg::trit_mul(xa, za)));
        x_new[col_a] = qst_pkg::trit_mul(2'd2, za);
        z_new[col_a] = qst_pkg::trit_mul(2'd2, xa);
      end
      qst_pkg::ACT_S3: begin
        p_new        = qst_pkg::trit_add(p_old, qst_pkg::trit_mul(xa, za));
        x_new[col_a] = qst_pkg::trit_add(xa, za);
      end
      qst_pkg::ACT_CZ3: begin
        p_new        = qst_pkg::trit_add(p_old,
                         qst_pkg::trit_mul(2'd2, qst_pkg::trit_mul(xa, zb)));
        x_new[col_a] = qst_pkg::trit_add(xa, zb);
        x_new[col_b] = qst_pkg::trit_add(xb, za);
      end
      qst_pkg::ACT_XPOW: p_new = qst_pkg::trit_add(p_old, qst_pkg::trit_mul(cur.power, za));
      qst_pkg::ACT_ZPOW: p_new = qst_pkg::trit_add(p_old, qst_pkg::trit_mul(cur.power, xa));
      default: p_new = p_old;
    endcase
  end

  assign wr_word = {p_new, z_new, x_new};
  assign ram_we  = s1_valid && (cur.kind == qst_pkg::KIND_GATE);

  always_comb begin
    res_in.status      = cur.status;
    res_in.outcome     = 2'd0;
    res_in.random_flag = 1'b0;
    if (cur.kind == qst_pkg::KIND_MEASURE) begin
      res_in.outcome     = found ? meas_outcome : 2'd0;
      res_in.random_flag = !found;
    end
  end

  assign res_push = (state == ST_DONE) && !res_full;

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    s1_addr <= IW'(row);
    if (s1_valid && cur.kind == qst_pkg::KIND_MEASURE && !found && xa != 2'd0) begin
      meas_outcome <= p_old;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      s1_valid  <= 1'b0;
      row_valid <= '0;
      found     <= 1'b0;
    end else begin
      s1_valid <= (state == ST_RUN);
      if (s1_valid && cur.kind == qst_pkg::KIND_MEASURE && xa != 2'd0) begin
        found <= 1'b1;
      end
      if (ram_we) begin
        row_valid[s1_addr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            row   <= '0;
            found <= 1'b0;
            if (cmd.kind == qst_pkg::KIND_GATE || cmd.kind == qst_pkg::KIND_MEASURE) begin
              state <= ST_RUN;
            end else begin
              state <= ST_DONE;
            end
            if (cmd.kind == qst_pkg::KIND_REINIT) begin
              row_valid <= '0;
            end
          end
        end
        ST_RUN: begin
          if (row == count - 5'd1) begin
            state <= ST_DRAIN;
          end else begin
            row <= row + 5'd1;
          end
        end
        ST_DRAIN: state <= ST_DONE;
        ST_DONE: begin
          if (!res_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_we) begin
        row_valid <= '0;
      end
    end
  end

  qst_fifo #(
    .WIDTH($bits(qst_pkg::res_t)),
    .DEPTH(2)
  ) u_res_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .full (res_full),
    .wdata(res_in),
    .pop  (pop),
    .empty(empty),
    .rdata(result)
  );

  `QST_ASSERT_IMPL(a_idle_drained, clk, rst, state == ST_IDLE, !s1_valid)
  `QST_ASSERT_IMPL(a_run_in_range, clk, rst, state == ST_RUN, row < count)
  `QST_ASSERT_NEXT(a_pop_leaves_idle, clk, rst, cmd_pop, state != ST_IDLE)

endmodule

// File: sv/qutrit_stabilizer_tableau_top.sv
// Qutrit stabilizer tableau: gate, measure and reinit requests over a mod-3 tableau.
// Gate and measure requests walk one tableau row per cycle (n = qutrit_count rows)
// through the row RAM's read and write ports, then pass DRAIN and DONE; other requests
// go from IDLE straight to DONE. Up to two requests and two results queue.
// Synchronous active-high reset: qutrit_count to min(16, MAX_QUTRITS), row valid bits
// clear at once so the tableau reads as the identity Z state with no clearing pass.
module qutrit_stabilizer_tableau_top #(
  parameter int MAX_QUTRITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  qst_pkg::req_t request,
  output logic          empty,
  input  logic          pop,
  output qst_pkg::res_t result,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_data
);

  logic [4:0]    count;
  logic          cmd_empty;
  logic          cmd_pop;
  qst_pkg::cmd_t cmd;

  qst_front #(
    .MAX_QUTRITS(MAX_QUTRITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .count    (count),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  qst_back #(
    .MAX_QUTRITS(MAX_QUTRITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .count    (count),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
